// ===== design/jas_pkg.sv =====
// Package: shared constants, types and register codes for the joystick axis scaler.
`timescale 1ns / 1ps
package jas_pkg;

    localparam int ADC_BITS = 12;
    localparam int SAMPLES  = 5;
    localparam int N_FIELDS = 5;
    localparam int FIELD_W  = 12;

    localparam int N_USED = (SAMPLES < N_FIELDS) ? SAMPLES : N_FIELDS;
    localparam int SMP_W  = (ADC_BITS < FIELD_W) ? ADC_BITS : FIELD_W;
    localparam int SUM_W  = SMP_W + $clog2(N_USED + 1);

    localparam int SCMAX_W = 10;
    localparam int SCMIN_W = 11;
    localparam int DEAD_W  = 14;
    localparam int TRAV_W  = 15;
    localparam int POS_W   = 15;

    localparam int DEN_W   = (SUM_W > TRAV_W) ? SUM_W : TRAV_W;
    localparam int SEEN_W  = DEN_W + 2;
    localparam int SMAG_W  = SCMIN_W;
    localparam int HUND_W  = 7;
    localparam int PROD_W  = DEN_W + SMAG_W;
    localparam int DVD_W   = PROD_W + HUND_W;
    localparam int QUO_W   = $clog2((1 << (SMAG_W - 1)) * 100 + 1);
    localparam int V_W     = QUO_W + 1;
    localparam int DZ_W    = V_W + 1;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [HUND_W-1:0] HUNDRED   = HUND_W'(100);
    localparam int                POS_LIMIT = 10000;

    localparam int N_REGS = 6;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(N_REGS);
    localparam int ADDR_W = IDX_W + 2;

    localparam logic [IDX_W-1:0] REG_SCALE_MAX    = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_SCALE_MIN    = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_DEAD_UPPER   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_DEAD_LOWER_H = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_DEAD_LOWER_V = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_INIT_TRAVEL  = IDX_W'(5);

    localparam logic OP_CAL  = 1'b0;
    localparam logic OP_MEAS = 1'b1;

    localparam logic STS_OK    = 1'b0;
    localparam logic STS_UNCAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_PREP,
        ST_MUL1,
        ST_MUL2,
        ST_DIV,
        ST_SIGN,
        ST_POST,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [SCMAX_W-1:0] scale_max;
        logic [SCMIN_W-1:0] scale_min;
        logic [DEAD_W-1:0]  dead_upper;
        logic [DEAD_W-1:0]  dead_lower_h;
        logic [DEAD_W-1:0]  dead_lower_v;
        logic [TRAV_W-1:0]  initial_travel;
    } t_cfg;

    typedef struct packed {
        logic capture;
        logic sum;
        logic prep;
        logic mul1;
        logic mul2;
        logic div_step;
        logic sign;
        logic post;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
    } t_dp_sts;

endpackage

// ===== design/jas_in_if.sv =====
// Interface: input item channel carrying opcode, axis and five ADC readings.
`timescale 1ns / 1ps
interface jas_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        axis;
    logic [11:0] sample_a;
    logic [11:0] sample_b;
    logic [11:0] sample_c;
    logic [11:0] sample_d;
    logic [11:0] sample_e;

    modport source (
        output valid, opcode, axis, sample_a, sample_b, sample_c, sample_d, sample_e,
        input  ready
    );
    modport sink (
        input  valid, opcode, axis, sample_a, sample_b, sample_c, sample_d, sample_e,
        output ready
    );
endinterface

// ===== design/jas_out_if.sv =====
// Interface: result item channel carrying position, axis echo and status.
`timescale 1ns / 1ps
interface jas_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] position;
    logic               axis_echo;
    logic               status;

    modport source (
        output valid, position, axis_echo, status,
        input  ready
    );
    modport sink (
        input  valid, position, axis_echo, status,
        output ready
    );
endinterface

// ===== design/joystick_axis_autocal_scaler_unit.sv =====
// Top level: joystick axis auto-calibration and scaling unit.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  i_in     | in  | valid/ready      | opcode, axis, sample_a..sample_e
//  o_out    | out | valid/ready      | position, axis_echo, status
//  apb      | in  | psel/penable     | paddr, pwdata, prdata (pready always 1)
//
// Calibrate or early measure: after accept the item passes ST_SUM and ST_PREP, then ST_OUT loads the result register.
// Measure: ST_MUL1, ST_MUL2, the 17-step restoring divider (one quotient bit a cycle), ST_SIGN, ST_POST, ST_OUT.
// Next item is accepted once the current one reaches the output register.
// A stalled output holds the result; the unit then waits with one item finished.
// Synchronous active-low reset; calibration state of both axes cleared.
`timescale 1ns / 1ps
module joystick_axis_autocal_scaler_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    jas_in_if.sink                      i_in,
    jas_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jas_pkg::ADDR_W-1:0]  paddr,
    input  logic [jas_pkg::DATA_W-1:0]  pwdata,
    output logic [jas_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import jas_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    jas_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    jas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    jas_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_opcode    (i_in.opcode),
        .i_axis      (i_in.axis),
        .i_sample_a  (i_in.sample_a),
        .i_sample_b  (i_in.sample_b),
        .i_sample_c  (i_in.sample_c),
        .i_sample_d  (i_in.sample_d),
        .i_sample_e  (i_in.sample_e),
        .o_position  (o_out.position),
        .o_axis_echo (o_out.axis_echo),
        .o_status    (o_out.status)
    );

`ifndef NO_ASSERTIONS
    a_one_item_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("item accepted while another is in work");

    a_uncal_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.position == '0))
        else $error("uncalibrated result carries nonzero position");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> ($signed(o_out.position) <= 15'sd10000 &&
                         $signed(o_out.position) >= -15'sd10000))
        else $error("position outside clamp range");

    a_load_after_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.out_load && o_out.valid) |-> o_out.ready)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== design/jas_cfg_regs.sv =====
// APB configuration register file for scale, dead zone and travel settings.
`timescale 1ns / 1ps
module jas_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [jas_pkg::ADDR_W-1:0]  paddr,
    input  logic [jas_pkg::DATA_W-1:0]  pwdata,
    output logic [jas_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output jas_pkg::t_cfg               o_cfg
);
    import jas_pkg::*;

    t_cfg             r_cfg;
    logic             wr_en;
    logic [IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[ADDR_W-1:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_max      <= SCMAX_W'(101);
            r_cfg.scale_min      <= SCMIN_W'(-101);
            r_cfg.dead_upper     <= DEAD_W'(20);
            r_cfg.dead_lower_h   <= DEAD_W'(25);
            r_cfg.dead_lower_v   <= DEAD_W'(30);
            r_cfg.initial_travel <= TRAV_W'(6143);
        end else if (wr_en) begin
            unique case (idx)
                REG_SCALE_MAX:    r_cfg.scale_max      <= pwdata[SCMAX_W-1:0];
                REG_SCALE_MIN:    r_cfg.scale_min      <= pwdata[SCMIN_W-1:0];
                REG_DEAD_UPPER:   r_cfg.dead_upper     <= pwdata[DEAD_W-1:0];
                REG_DEAD_LOWER_H: r_cfg.dead_lower_h   <= pwdata[DEAD_W-1:0];
                REG_DEAD_LOWER_V: r_cfg.dead_lower_v   <= pwdata[DEAD_W-1:0];
                REG_INIT_TRAVEL:  r_cfg.initial_travel <= pwdata[TRAV_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCALE_MAX:    prdata = DATA_W'(r_cfg.scale_max);
            REG_SCALE_MIN:    prdata = DATA_W'($signed(r_cfg.scale_min));
            REG_DEAD_UPPER:   prdata = DATA_W'(r_cfg.dead_upper);
            REG_DEAD_LOWER_H: prdata = DATA_W'(r_cfg.dead_lower_h);
            REG_DEAD_LOWER_V: prdata = DATA_W'(r_cfg.dead_lower_v);
            REG_INIT_TRAVEL:  prdata = DATA_W'(r_cfg.initial_travel);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== design/jas_ctrl.sv =====
// Controller state machine: sequences sum, calibration update, multiply, divide, sign, dead zone and output.
`timescale 1ns / 1ps
module jas_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  jas_pkg::t_dp_sts  i_sts,
    output jas_pkg::t_dp_cmd  o_cmd
);
    import jas_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             r_out_valid;
    logic             n_out_valid;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_PREP;
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.skip ? ST_OUT : ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_cnt      = '0;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    n_state = ST_SIGN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_SIGN: begin
                o_cmd.sign = 1'b1;
                n_state    = ST_POST;
            end
            ST_POST: begin
                o_cmd.post = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

// ===== design/jas_datapath.sv =====
// Datapath: sample sum, per-axis calibration state, scaling multiply, serial divider, dead zone and clamp.
`timescale 1ns / 1ps
module jas_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  jas_pkg::t_cfg                     i_cfg,
    input  jas_pkg::t_dp_cmd                  i_cmd,
    output jas_pkg::t_dp_sts                  o_sts,
    input  logic                              i_opcode,
    input  logic                              i_axis,
    input  logic [jas_pkg::FIELD_W-1:0]       i_sample_a,
    input  logic [jas_pkg::FIELD_W-1:0]       i_sample_b,
    input  logic [jas_pkg::FIELD_W-1:0]       i_sample_c,
    input  logic [jas_pkg::FIELD_W-1:0]       i_sample_d,
    input  logic [jas_pkg::FIELD_W-1:0]       i_sample_e,
    output logic signed [jas_pkg::POS_W-1:0]  o_position,
    output logic                              o_axis_echo,
    output logic                              o_status
);
    import jas_pkg::*;

    localparam logic signed [DZ_W-1:0] POS_MAX = DZ_W'(POS_LIMIT);
    localparam logic signed [DZ_W-1:0] POS_MIN = -DZ_W'(POS_LIMIT);

    logic                     r_op;
    logic                     r_axis;
    logic [FIELD_W-1:0]       r_smp [N_FIELDS];
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         r_center [2];
    logic signed [SEEN_W-1:0] r_min [2];
    logic signed [SEEN_W-1:0] r_max [2];
    logic                     r_cal [2];
    logic [DEN_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_den;
    logic [SMAG_W-1:0]        r_smag;
    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic [DEN_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_quo;
    logic signed [V_W-1:0]    r_v;
    logic signed [POS_W-1:0]  r_res;
    logic                     r_status;
    logic signed [POS_W-1:0]  r_o_pos;
    logic                     r_o_axis;
    logic                     r_o_status;

    logic [SUM_W-1:0]         sum_acc;
    logic signed [SEEN_W-1:0] sum_s;
    logic signed [SEEN_W-1:0] trav_s;
    logic signed [SEEN_W-1:0] c_s;
    logic signed [SEEN_W-1:0] min_w;
    logic signed [SEEN_W-1:0] max_w;
    logic signed [SEEN_W-1:0] den_p;
    logic signed [SEEN_W-1:0] den_n;
    logic signed [SEEN_W-1:0] num_d;
    logic                     pos_side;
    logic [SMAG_W-1:0]        smin_mag;
    logic [DVD_W-1:0]         dvd;
    logic [DEN_W:0]           shifted;
    logic                     ge;
    logic [V_W-1:0]           q_ext;
    logic signed [DZ_W-1:0]   v_e;
    logic signed [DZ_W-1:0]   du;
    logic signed [DZ_W-1:0]   dl;
    logic signed [DZ_W-1:0]   v_hi;
    logic signed [DZ_W-1:0]   v_lo;
    logic signed [DZ_W-1:0]   t_dz;
    logic signed [DZ_W-1:0]   t_cl;

    always_comb begin
        sum_acc = '0;
        for (int i = 0; i < N_USED; i++) begin
            sum_acc = sum_acc + SUM_W'(r_smp[i][SMP_W-1:0]);
        end
    end

    assign sum_s    = $signed(SEEN_W'(r_sum));
    assign trav_s   = $signed(SEEN_W'(i_cfg.initial_travel));
    assign c_s      = $signed(SEEN_W'(r_center[r_axis]));
    assign min_w    = (sum_s < r_min[r_axis]) ? sum_s : r_min[r_axis];
    assign max_w    = (sum_s > r_max[r_axis]) ? sum_s : r_max[r_axis];
    assign pos_side = (sum_s >= c_s);
    assign den_p    = max_w - c_s;
    assign den_n    = c_s - min_w;
    assign num_d    = pos_side ? (sum_s - c_s) : (c_s - sum_s);
    assign smin_mag = i_cfg.scale_min[SCMIN_W-1] ? (~i_cfg.scale_min + 1'b1)
                                                  : i_cfg.scale_min;

    assign o_sts.skip = (r_op == OP_CAL) || !r_cal[r_axis];

    assign dvd     = DVD_W'(r_prod) * DVD_W'(HUNDRED);
    assign shifted = {r_rem, r_quo[QUO_W-1]};
    assign ge      = (shifted >= {1'b0, r_den});
    assign q_ext   = (r_den == '0) ? '0 : V_W'(r_quo);

    assign v_e  = DZ_W'(r_v);
    assign du   = $signed(DZ_W'(i_cfg.dead_upper));
    assign dl   = $signed(DZ_W'(r_axis ? i_cfg.dead_lower_v : i_cfg.dead_lower_h));
    assign v_hi = v_e - du;
    assign v_lo = v_e + dl;

    always_comb begin
        if (v_lo >= 0 && v_hi <= 0) begin
            t_dz = '0;
        end else if (v_e >= 0) begin
            t_dz = v_hi;
        end else begin
            t_dz = v_lo;
        end
        if (t_dz > POS_MAX) begin
            t_cl = POS_MAX;
        end else if (t_dz < POS_MIN) begin
            t_cl = POS_MIN;
        end else begin
            t_cl = t_dz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal[0] <= 1'b0;
            r_cal[1] <= 1'b0;
        end else if (i_cmd.prep && r_op == OP_CAL) begin
            r_cal[r_axis] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_axis   <= i_axis;
            r_smp[0] <= i_sample_a;
            r_smp[1] <= i_sample_b;
            r_smp[2] <= i_sample_c;
            r_smp[3] <= i_sample_d;
            r_smp[4] <= i_sample_e;
        end
        if (i_cmd.sum) begin
            r_sum <= sum_acc;
        end
        if (i_cmd.prep) begin
            r_res <= '0;
            if (r_op == OP_CAL) begin
                r_center[r_axis] <= r_sum;
                r_min[r_axis]    <= sum_s - trav_s;
                r_max[r_axis]    <= sum_s + trav_s;
                r_status         <= STS_OK;
            end else if (!r_cal[r_axis]) begin
                r_status <= STS_UNCAL;
            end else begin
                r_min[r_axis] <= min_w;
                r_max[r_axis] <= max_w;
                r_num         <= num_d[DEN_W-1:0];
                r_den         <= pos_side ? den_p[DEN_W-1:0] : den_n[DEN_W-1:0];
                r_smag        <= pos_side ? SMAG_W'(i_cfg.scale_max) : smin_mag;
                r_neg         <= !pos_side && i_cfg.scale_min[SCMIN_W-1];
                r_status      <= STS_OK;
            end
        end
        if (i_cmd.mul1) begin
            r_prod <= PROD_W'(r_num) * PROD_W'(r_smag);
        end
        if (i_cmd.mul2) begin
            r_rem <= dvd[QUO_W +: DEN_W];
            r_quo <= dvd[QUO_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= ge ? DEN_W'(shifted - {1'b0, r_den}) : shifted[DEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], ge};
        end
        if (i_cmd.sign) begin
            r_v <= r_neg ? -$signed(q_ext) : $signed(q_ext);
        end
        if (i_cmd.post) begin
            r_res <= t_cl[POS_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_o_pos    <= r_res;
            r_o_axis   <= r_axis;
            r_o_status <= r_status;
        end
    end

    assign o_position  = r_o_pos;
    assign o_axis_echo = r_o_axis;
    assign o_status    = r_o_status;

endmodule
